// ===== hw/rtl/dle_frame_deframer_checksum_assert.svh =====
// Assertion macros for the DLE deframer.
`ifndef DLE_FRAME_DEFRAMER_CHECKSUM_ASSERT_SVH
`define DLE_FRAME_DEFRAMER_CHECKSUM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DFD_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfd check failed");

// Next-cycle implication, checked out of reset.
`define DFD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfd check failed");

`endif

// ===== hw/rtl/dfd_pkg.sv =====
// Shared types and constants for the DLE deframer.
`timescale 1ns / 1ps
package dfd_pkg;

  // End-of-frame status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SUM  = 3'd1,
    ST_STRAY    = 3'd2,
    ST_LONE_ESC = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  // Configuration register indexes
  localparam logic CFG_ESCAPE = 1'b0;
  localparam logic CFG_END    = 1'b1;

  // Register reset values
  localparam logic [7:0] ESCAPE_RESET = 8'h10;
  localparam logic [7:0] END_RESET    = 8'h03;

  // Framing state
  typedef struct packed {
    logic       inside_frame;
    logic       escape_pending;
    logic [7:0] running_sum;
    logic [7:0] byte_count;
  } frame_state_t;

  // One result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    status_t    status;
    logic [7:0] body_length;
  } result_t;

endpackage

// ===== hw/rtl/dfd_core.sv =====
// Per-byte framing decision: next state and optional result.
`timescale 1ns / 1ps
module dfd_core #(
  parameter int MAX_BODY = 255
) (
  input  logic                 [7:0] rx_byte,
  input  logic                 [7:0] escape_byte,
  input  logic                 [7:0] end_byte,
  input  dfd_pkg::frame_state_t      cur,
  output dfd_pkg::frame_state_t      nxt,
  output logic                       has_result,
  output dfd_pkg::result_t           result
);
  import dfd_pkg::*;

  logic       is_escape;
  logic       is_end;
  logic       too_long;
  logic [7:0] sum_add;
  logic [7:0] cnt_inc;

  assign is_escape = (rx_byte == escape_byte);
  assign is_end    = (rx_byte == end_byte);
  assign too_long  = (cur.byte_count >= 8'(MAX_BODY));
  assign sum_add   = cur.running_sum + rx_byte;
  assign cnt_inc   = cur.byte_count + 8'd1;

  // Framing decision
  always_comb begin
    nxt        = cur;
    has_result = 1'b0;
    result     = '{out_byte: 8'd0, frame_end: 1'b1, status: ST_OK,
                   body_length: cur.byte_count};
    if (!cur.inside_frame) begin
      if (is_escape) begin
        // frame start
        nxt.inside_frame   = 1'b1;
        nxt.escape_pending = 1'b0;
        nxt.running_sum    = 8'd0;
        nxt.byte_count     = 8'd0;
      end else begin
        has_result         = 1'b1;
        result.status      = ST_STRAY;
        result.body_length = 8'd0;
      end
    end else if (!cur.escape_pending && is_escape) begin
      nxt.escape_pending = 1'b1;
    end else if (!cur.escape_pending || is_escape) begin
      // data byte, plain or doubled escape
      nxt.escape_pending = 1'b0;
      has_result         = 1'b1;
      if (too_long) begin
        nxt.inside_frame = 1'b0;
        result.status    = ST_TOO_LONG;
      end else begin
        nxt.running_sum    = sum_add;
        nxt.byte_count     = cnt_inc;
        result.out_byte    = rx_byte;
        result.frame_end   = 1'b0;
        result.body_length = cnt_inc;
      end
    end else begin
      // escape then end closes; anything else aborts
      nxt.escape_pending = 1'b0;
      nxt.inside_frame   = 1'b0;
      has_result         = 1'b1;
      if (is_end) begin
        result.status = (cur.running_sum == 8'd0) ? ST_OK : ST_BAD_SUM;
      end else begin
        result.status = ST_LONE_ESC;
      end
    end
  end

endmodule

// ===== hw/rtl/dfd_out_buf.sv =====
// Two-entry output register with skid stage.
`timescale 1ns / 1ps
module dfd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dfd_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output dfd_pkg::result_t out_data
);
  import dfd_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (out_valid && !pop && push && !skid_valid) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== hw/rtl/dle_frame_deframer_checksum.sv =====
// DLE deframer: the result beat of each accepted byte is registered in the output buffer.
// Throughput is one byte per cycle while rx_ready is high; the state updates once per accepted byte.
// A two-entry output buffer keeps input flowing while one result beat waits.
// rx_ready drops only when both output entries hold beats.
// Reset clears framing state, output buffer and loads escape 0x10, end 0x03.
`timescale 1ns / 1ps
`include "dle_frame_deframer_checksum_assert.svh"
module dle_frame_deframer_checksum #(
  parameter int MAX_BODY = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic [2:0] status,
  output logic [7:0] body_length
);
  import dfd_pkg::*;

  logic         [7:0] escape_byte;
  logic         [7:0] end_byte;
  frame_state_t       state;
  frame_state_t       state_next;
  logic               has_result;
  result_t            result;
  result_t            out_data;
  logic               rx_fire;

  assign rx_fire = rx_valid && rx_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_byte <= ESCAPE_RESET;
      end_byte    <= END_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ESCAPE: escape_byte <= cfg_data;
        CFG_END:    end_byte    <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Framing decision
  dfd_core #(
    .MAX_BODY(MAX_BODY)
  ) u_core (
    .rx_byte    (rx_byte),
    .escape_byte(escape_byte),
    .end_byte   (end_byte),
    .cur        (state),
    .nxt        (state_next),
    .has_result (has_result),
    .result     (result)
  );

  // Framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (rx_fire) begin
      state <= state_next;
    end
  end

  // Result buffer
  dfd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (rx_fire && has_result),
    .push_data(result),
    .can_push (rx_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign out_byte    = out_data.out_byte;
  assign frame_end   = out_data.frame_end;
  assign status      = out_data.status;
  assign body_length = out_data.body_length;

  // Checks
  `DFD_ASSERT_NOW(a_body_ok, clk, rst, out_valid && !frame_end, status == ST_OK)
  `DFD_ASSERT_NOW(a_body_len, clk, rst, out_valid && !frame_end, body_length != 8'd0)
  `DFD_ASSERT_NOW(a_stall_full, clk, rst, !rx_ready, out_valid)
  `DFD_ASSERT_NOW(a_pend_inside, clk, rst, state.escape_pending, state.inside_frame)
  `DFD_ASSERT_NEXT(a_start, clk, rst,
    rx_fire && !state.inside_frame && (rx_byte == escape_byte), state.inside_frame)

endmodule

// ===== test/dle_frame_deframer_checksum_tb.sv =====
// Self-checking testbench for the DLE deframer with additive checksum.
`timescale 1ns / 1ps
module dle_frame_deframer_checksum_tb;
  import dfd_pkg::*;

  localparam int BODY_LIMIT = 255;
  localparam int LONG_HOLD  = 300;

  // Opening beats at the reset escape 0x10 and end 0x03
  localparam logic [7:0] OPENING [21] = '{
    8'h00, 8'hFF,                                      // strays at both extremes
    8'h10, 8'h10, 8'h03,                               // empty frame
    8'h10, 8'h10, 8'h10, 8'hFF, 8'h00, 8'hF1, 8'h10, 8'h03, // stuffed escape, sum zero
    8'h10, 8'h03, 8'h10, 8'h03,                        // end byte as data, bad sum
    8'h10, 8'h22, 8'h10, 8'h55                         // lone escape
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       frame_end;
  logic [2:0] status;
  logic [7:0] body_length;

  // Bytes waiting to be offered, and result beats the deframer still owes
  logic [7:0] rx_pending[$];
  result_t    frame_beats_due[$];

  // Shadow of the deframer registers and framing state
  logic [7:0] esc_code = ESCAPE_RESET;
  logic [7:0] end_code = END_RESET;
  logic       frame_open = 1'b0;
  logic       esc_held = 1'b0;
  logic [7:0] body_sum = 8'h00;
  logic [7:0] body_count = 8'h00;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  long_hold_req = 1'b0;
  int  hold_left = 0;
  int  fail_count = 0;

  dle_frame_deframer_checksum #(.MAX_BODY(BODY_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rx_valid(rx_valid),
    .rx_ready(rx_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .frame_end(frame_end),
    .status(status),
    .body_length(body_length)
  );

  always #1 clk = ~clk;

  // Queue one end-of-frame beat and drop back to hunting for a start
  function automatic void close_with(input status_t code);
    result_t beat;
    beat.out_byte = 8'h00;
    beat.frame_end = 1'b1;
    beat.status = code;
    beat.body_length = body_count;
    frame_beats_due.push_back(beat);
    frame_open = 1'b0;
    esc_held = 1'b0;
  endfunction

  // Add one unstuffed byte to the body, or abort if the body is full
  function automatic void absorb_body_byte(input logic [7:0] b);
    result_t beat;
    if (body_count >= BODY_LIMIT) begin
      close_with(ST_TOO_LONG);
    end else begin
      body_sum = body_sum + b;
      body_count = body_count + 8'd1;
      beat.out_byte = b;
      beat.frame_end = 1'b0;
      beat.status = ST_OK;
      beat.body_length = body_count;
      frame_beats_due.push_back(beat);
    end
  endfunction

  // Advance the framing state by one received byte
  function automatic void deframe_byte(input logic [7:0] b);
    if (!frame_open) begin
      if (b == esc_code) begin
        frame_open = 1'b1;
        esc_held = 1'b0;
        body_sum = 8'h00;
        body_count = 8'h00;
      end else begin
        body_count = body_count;
        frame_beats_due.push_back('{8'h00, 1'b1, ST_STRAY, 8'h00});
      end
    end else if (!esc_held) begin
      if (b == esc_code) esc_held = 1'b1;
      else absorb_body_byte(b);
    end else begin
      esc_held = 1'b0;
      if (b == esc_code) absorb_body_byte(b);
      else if (b == end_code) close_with(body_sum == 8'h00 ? ST_OK : ST_BAD_SUM);
      else close_with(ST_LONE_ESC);
    end
  endfunction

  // Body byte, doubled when it matches the escape code
  function automatic void push_body(input logic [7:0] b);
    rx_pending.push_back(b);
    if (b == esc_code) rx_pending.push_back(b);
  endfunction

  // Random body content, leaning toward the escape and end codes
  function automatic logic [7:0] body_byte();
    int pick;
    pick = $urandom_range(15);
    if (pick < 2) return esc_code;
    if (pick == 2) return end_code;
    return 8'($urandom_range(255));
  endfunction

  function automatic int frame_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 13);
    return $urandom_range(12);
  endfunction

  // Whole frame; the last body byte can be chosen to bring the sum to zero
  function automatic void push_frame(input int len, input bit zero_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    rx_pending.push_back(esc_code);
    for (int i = 0; i < len; i++) begin
      b = body_byte();
      if (zero_sum && i == len - 1) b = 8'h00 - sum;
      sum = sum + b;
      push_body(b);
    end
    rx_pending.push_back(esc_code);
    rx_pending.push_back(end_code);
  endfunction

  // Mostly well-formed frames, the rest broken frames, strays and noise
  function automatic void fill_random(input int count);
    int goal;
    int pick;
    logic [7:0] b;
    goal = rx_pending.size() + count;
    while (rx_pending.size() < goal) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_frame(frame_len(), 1'b1);
      end else if (pick < 72) begin
        push_frame(frame_len(), 1'b0);
      end else if (pick < 82) begin
        // lone escape after a short body
        rx_pending.push_back(esc_code);
        repeat ($urandom_range(4)) push_body(body_byte());
        rx_pending.push_back(esc_code);
        do b = 8'($urandom_range(255)); while (b == esc_code || b == end_code);
        rx_pending.push_back(b);
      end else if (pick < 92) begin
        // strays between frames
        repeat ($urandom_range(3, 1)) begin
          do b = 8'($urandom_range(255)); while (b == esc_code);
          rx_pending.push_back(b);
        end
      end else begin
        repeat ($urandom_range(4, 1)) rx_pending.push_back(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_ESCAPE) esc_code = val;
    else end_code = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every byte is taken and every owed beat has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (rx_pending.size() != 0 || rx_valid || frame_beats_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Input driver: predict on each accepted beat, then offer the next byte
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && rx_ready) deframe_byte(rx_byte);
      if (!rx_valid || rx_ready) begin
        if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_valid <= 1'b1;
          rx_byte <= rx_pending.pop_front();
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each accepted beat, then pick the next ready
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_beats_due.size() == 0) begin
          $error("result beat with none owed: out_byte %0h frame_end %0b status %0d",
                 out_byte, frame_end, status);
          fail_count++;
        end else begin
          want = frame_beats_due.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte);
            fail_count++;
          end
          if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (body_length !== want.body_length) begin
            $error("body_length: expected %0d, actual %0d", want.body_length, body_length);
            fail_count++;
          end
        end
      end
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [7:0] pick_esc;
    logic [7:0] pick_end;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed beats at the reset registers, no idling
    foreach (OPENING[i]) rx_pending.push_back(OPENING[i]);
    wait_drained();
    fill_random(170);
    wait_drained();

    // extreme codes, sender idling, pausing for the results between chunks
    write_reg(CFG_ESCAPE, 8'h00);
    write_reg(CFG_END, 8'hFF);
    send_idle_pct = 62;
    repeat (3) begin
      fill_random(60);
      wait_drained();
    end
    // body runs past the length limit
    rx_pending.push_back(esc_code);
    repeat (BODY_LIMIT + 1) push_body(body_byte());
    wait_drained();

    // swapped extremes, receiver stalling, with one long hold-off up front
    write_reg(CFG_ESCAPE, 8'hFF);
    write_reg(CFG_END, 8'h00);
    send_idle_pct = 0;
    recv_stall_pct = 62;
    long_hold_req = 1'b1;
    fill_random(170);
    wait_drained();

    // random distinct codes, both sides idling
    pick_esc = 8'($urandom_range(255));
    do pick_end = 8'($urandom_range(255)); while (pick_end == pick_esc);
    write_reg(CFG_ESCAPE, pick_esc);
    write_reg(CFG_END, pick_end);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    fill_random(170);
    wait_drained();

    // escape equal to end: frames never close on the end code
    write_reg(CFG_ESCAPE, 8'h5A);
    write_reg(CFG_END, 8'h5A);
    fill_random(40);
    wait_drained();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
